// ===== hdl/swld_pkg.sv =====
package swld_pkg;

  // sync word "HEAD", first byte at index 0
  localparam int unsigned SyncLen = 4;
  localparam logic [SyncLen-1:0][7:0] SyncWord = {8'h44, 8'h41, 8'h45, 8'h48};

  // sync word plus the two length bytes
  localparam logic [16:0] HeaderLen = 17'd6;

  localparam logic EvPayload = 1'b0;
  localparam logic EvReject  = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        event_kind;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [15:0] announced_length;
  } swld_result_t;

endpackage

// ===== hdl/swld_if.sv =====
interface swld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swld_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic [15:0] announced_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output last_byte, output announced_length, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input last_byte, input announced_length, output ready);
endinterface

interface swld_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] expected_length;

  modport source (output valid, output expected_length, input ready);
  modport sink   (input valid, input expected_length, output ready);
endinterface

// ===== hdl/sync_word_length_deframer_unit.sv =====
// Frame receiver for a byte stream: hunts for the sync word "HEAD", reads a
// 16-bit little-endian length, rejects frames whose length is zero, differs
// from expected_length or does not fit the frame buffer (length plus six
// header bytes above FRAME_BUFFER_BYTES), and otherwise passes each payload
// byte out with the last one marked. The parser updates its state in the
// cycle a byte is taken, and a result word lands in a single output register
// in the cycle after. A new byte is taken in every cycle unless that register
// holds a word the sink has not yet taken.
// Sync and length bytes give no output word; each payload byte gives one, a
// rejection gives one. expected_length resets to 1 and may only be written
// while the block is idle.
module sync_word_length_deframer_unit #(
  parameter int unsigned FRAME_BUFFER_BYTES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swld_cfg_if.sink   cfg_i,
  swld_in_if.sink    rx_i,
  swld_out_if.source ev_o
);
  import swld_pkg::*;

  swld_result_t res_new;
  swld_result_t res_out;
  logic         out_free;
  logic         rx_fire;
  logic [6:0]   exp_len;

  // config writes never stall
  assign cfg_i.ready = 1'b1;

  // input taken whenever the result register can take a word
  assign rx_i.ready = out_free;
  assign rx_fire    = rx_i.valid && out_free;

  swld_parser #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_i.valid),
    .cfg_len_i (cfg_i.expected_length),
    .fire_i    (rx_fire),
    .rx_byte_i (rx_i.rx_byte),
    .res_o     (res_new),
    .exp_len_o (exp_len)
  );

  swld_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_new),
    .ready_i (ev_o.ready),
    .free_o  (out_free),
    .res_o   (res_out)
  );

  // result word to the sink
  assign ev_o.valid            = res_out.valid;
  assign ev_o.event_kind       = res_out.event_kind;
  assign ev_o.payload_byte     = res_out.payload_byte;
  assign ev_o.last_byte        = res_out.last_byte;
  assign ev_o.announced_length = res_out.announced_length;

  // a byte that makes a result shows up at the output in the next cycle
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && res_new.valid |=> ev_o.valid)
    else $error("result word lost");

  // payload words only come from frames of an accepted (short) length
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.valid && ev_o.event_kind == EvPayload |->
      ev_o.announced_length[15:7] == 9'd0 && ev_o.announced_length != 16'd0)
    else $error("payload word with bad length");

  // a rejection never carries payload data or a last mark
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.valid && ev_o.event_kind == EvReject |->
      ev_o.payload_byte == 8'd0 && !ev_o.last_byte)
    else $error("rejection carries payload");

  // a rejected length differs from the expected one unless it is zero or too big
  a_reject_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.valid && ev_o.event_kind == EvReject |->
      ev_o.announced_length != {9'd0, exp_len} ||
      ev_o.announced_length == 16'd0 ||
      ({1'b0, ev_o.announced_length} + HeaderLen) > 17'(FRAME_BUFFER_BYTES))
    else $error("good length rejected");

endmodule

// ===== hdl/swld_parser.sv =====
module swld_parser #(
  parameter int unsigned FRAME_BUFFER_BYTES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_len_i,
  input  logic                  fire_i,
  input  logic [7:0]            rx_byte_i,
  output swld_pkg::swld_result_t res_o,
  output logic [6:0]            exp_len_o
);
  import swld_pkg::*;

  typedef enum logic [2:0] {
    PhSync0, PhSync1, PhSync2, PhSync3, PhLenLo, PhLenHi, PhPayload
  } phase_e;

  localparam logic [16:0] FrameLimit = 17'(FRAME_BUFFER_BYTES);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [6:0]  remain_q, remain_d;
  logic [6:0]  frame_len_q, frame_len_d;
  logic [6:0]  exp_len_q;
  logic [15:0] len;
  logic [6:0]  remain_dec;
  logic [1:0]  matched;
  logic        bad;

  assign len        = {rx_byte_i, len_lo_q};
  assign remain_dec = remain_q - 7'd1;
  assign bad = (len == 16'd0) || (len != {9'd0, exp_len_q}) ||
               (({1'b0, len} + HeaderLen) > FrameLimit);
  assign exp_len_o = exp_len_q;

  always_comb begin
    phase_d     = phase_q;
    len_lo_d    = len_lo_q;
    remain_d    = remain_q;
    frame_len_d = frame_len_q;
    matched     = 2'd0;
    res_o       = '0;
    unique case (phase_q)
      PhLenLo: begin
        len_lo_d = rx_byte_i;
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        if (bad) begin
          res_o.valid            = 1'b1;
          res_o.event_kind       = EvReject;
          res_o.announced_length = len;
          phase_d                = PhSync0;
          remain_d               = 7'd0;
        end else begin
          frame_len_d = len[6:0];
          remain_d    = len[6:0];
          phase_d     = PhPayload;
        end
      end
      PhPayload: begin
        remain_d               = remain_dec;
        res_o.valid            = 1'b1;
        res_o.event_kind       = EvPayload;
        res_o.payload_byte     = rx_byte_i;
        res_o.last_byte        = (remain_dec == 7'd0);
        res_o.announced_length = {9'd0, frame_len_q};
        if (remain_dec == 7'd0) begin
          phase_d = PhSync0;
        end
      end
      default: begin
        // sync hunt, restart on the first sync byte after a mismatch
        if (phase_q == PhSync1 || phase_q == PhSync2 || phase_q == PhSync3) begin
          matched = phase_q[1:0];
        end
        if (rx_byte_i == SyncWord[matched]) begin
          phase_d = phase_e'({1'b0, matched} + 3'd1);
        end else if (rx_byte_i == SyncWord[0]) begin
          phase_d = PhSync1;
        end else begin
          phase_d = PhSync0;
        end
      end
    endcase
    if (!fire_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSync0;
      len_lo_q    <= 8'd0;
      remain_q    <= 7'd0;
      frame_len_q <= 7'd0;
      exp_len_q   <= 7'd1;
    end else begin
      if (cfg_we_i) begin
        exp_len_q <= cfg_len_i;
      end
      if (fire_i) begin
        phase_q     <= phase_d;
        len_lo_q    <= len_lo_d;
        remain_q    <= remain_d;
        frame_len_q <= frame_len_d;
      end
    end
  end

endmodule

// ===== hdl/swld_out_reg.sv =====
module swld_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swld_pkg::swld_result_t res_i,
  input  logic                  ready_i,
  output logic                  free_o,
  output swld_pkg::swld_result_t res_o
);
  import swld_pkg::*;

  logic         valid_q, valid_d;
  swld_result_t data_q;

  // room when empty or the held word leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swld_pkg::*;

  // frame buffer size handed to the block
  localparam int FrameBytes = 128;
  // parser phases past the sync-match counts 0..3
  localparam logic [2:0] PhLenLo = 3'd4;
  localparam logic [2:0] PhLenHi = 3'd5;
  localparam logic [2:0] PhPayload = 3'd6;
  // cycles without any accepted word before the run is called hung
  localparam int StallLimit = 2000;
  // settle time after the last result, covers the output register stage
  localparam int DrainCycles = 8;
  // mismatches printed in full, later ones only counted
  localparam int ShownFailures = 10;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [15:0] announced_length;
  } deframe_word_t;

  // keeps its own copy of the parser state and the queue of words it predicts
  class deframe_scoreboard;
    deframe_word_t predicted_words[$];
    logic [6:0]    expected_length = 7'd1;
    logic [2:0]    parse_phase = 3'd0;
    logic [7:0]    length_lo = 8'd0;
    logic [6:0]    bytes_left = 7'd0;
    logic [15:0]   frame_length = 16'd0;
    int            failures = 0;

    function void set_expected_length(logic [6:0] value);
      expected_length = value;
    endfunction

    function int pending();
      return predicted_words.size();
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] rx);
      logic [15:0]   len;
      deframe_word_t w;
      if (parse_phase < PhLenLo) begin
        if (rx == SyncWord[parse_phase[1:0]]) begin
          parse_phase = parse_phase + 3'd1;
        end else begin
          parse_phase = (rx == SyncWord[0]) ? 3'd1 : 3'd0;
        end
      end else if (parse_phase == PhLenLo) begin
        length_lo = rx;
        parse_phase = PhLenHi;
      end else if (parse_phase == PhLenHi) begin
        len = {rx, length_lo};
        // zero, wrong or too big for the buffer: one rejection word
        if (len == 16'd0 || len != {9'd0, expected_length} ||
            int'(len) + int'(HeaderLen) > FrameBytes) begin
          w = '{EvReject, 8'd0, 1'b0, len};
          predicted_words.push_back(w);
          parse_phase = 3'd0;
          bytes_left = 7'd0;
        end else begin
          frame_length = len;
          bytes_left = len[6:0];
          parse_phase = PhPayload;
        end
      end else begin
        // payload bytes are passed through, never matched against the sync word
        bytes_left = bytes_left - 7'd1;
        w = '{EvPayload, rx, bytes_left == 7'd0, frame_length};
        predicted_words.push_back(w);
        if (bytes_left == 7'd0) begin
          parse_phase = 3'd0;
        end
      end
    endfunction

    function void check_word(deframe_word_t got);
      deframe_word_t want;
      if (predicted_words.size() == 0) begin
        failures++;
        if (failures <= ShownFailures) begin
          $display("unexpected word: kind %0d byte %02h last %0d len %0d",
                   got.event_kind, got.payload_byte, got.last_byte, got.announced_length);
        end
        return;
      end
      want = predicted_words.pop_front();
      if (got.event_kind !== want.event_kind || got.payload_byte !== want.payload_byte ||
          got.last_byte !== want.last_byte ||
          got.announced_length !== want.announced_length) begin
        failures++;
        if (failures <= ShownFailures) begin
          $display("mismatch: expected kind %0d byte %02h last %0d len %0d",
                   want.event_kind, want.payload_byte, want.last_byte, want.announced_length);
          $display("          actual   kind %0d byte %02h last %0d len %0d",
                   got.event_kind, got.payload_byte, got.last_byte, got.announced_length);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  swld_cfg_if cfg_if ();
  swld_in_if  rx_if ();
  swld_out_if ev_if ();

  sync_word_length_deframer_unit #(
    .FRAME_BUFFER_BYTES(FrameBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .rx_i  (rx_if),
    .ev_o  (ev_if)
  );

  deframe_scoreboard sb = new();

  // current register setting, used to build well-formed frames
  logic [6:0] length_setting = 7'd1;
  // no sender gaps and no receiver stalls while set
  bit calm = 1'b0;
  int burst_left = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows a mode that is picked at random
  // ---------------------------------------------------------------------------
  initial begin : ready_pattern
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    ev_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) begin
        mode = $urandom_range(0, 3);
      end
      if (calm) begin
        ev_if.ready = 1'b1;
      end else begin
        case (mode)
          0: ev_if.ready = 1'b1;
          1: ev_if.ready = 1'($urandom_range(0, 1));
          2: ev_if.ready = ($urandom_range(0, 3) == 0);
          default: ev_if.ready = ((cyc / 8) % 3 != 0);  // long stretches held off
        endcase
      end
      cyc++;
    end
  end

  // every output word taken by the sink goes to the scoreboard
  always @(posedge clk_i) begin
    if (ev_if.valid && ev_if.ready) begin
      sb.check_word({ev_if.event_kind, ev_if.payload_byte, ev_if.last_byte,
                     ev_if.announced_length});
    end
  end

  // watchdog on cycles where no channel moves a word
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // one received byte; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] rx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!calm && $urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk_i);
          rx_if.valid = 1'b0;
        end
      end
    end
    @(negedge clk_i);
    rx_if.valid = 1'b1;
    rx_if.rx_byte = rx;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_byte(rx);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_sync();
    for (int i = 0; i < SyncLen; i++) begin
      send_byte(SyncWord[2'(i)]);
    end
  endtask

  // length field goes out little-endian
  task automatic send_length(input logic [15:0] len);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  // byte biased toward the sync letters, to stress the hunt
  function automatic logic [7:0] hunt_byte();
    if ($urandom_range(0, 1) == 1) begin
      return SyncWord[2'($urandom_range(0, SyncLen - 1))];
    end
    return 8'($urandom);
  endfunction

  // announced length that mostly misses the setting, near misses included
  function automatic logic [15:0] odd_length();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return {9'd0, length_setting} + 16'd1;
      2: return {9'd0, length_setting} - 16'd1;
      3: return {8'($urandom_range(1, 255)), 1'b0, length_setting};
      4: return 16'($urandom);
      default: return 16'($urandom_range(120, 128));
    endcase
  endfunction

  task automatic write_expected_length(input logic [6:0] value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.expected_length = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_expected_length(value);
    length_setting = value;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // stop sending, wait for every predicted word, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    rx_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly well-formed frames, the rest wrong lengths, broken sync and noise
  task automatic run_traffic(input int budget);
    int start_count;
    int pick;
    int n;
    int cut;
    bit sync_heavy;
    logic [15:0] len;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = {9'd0, length_setting};
        n = len;
        // rejected setting: a few stray bytes follow the header
        if (len == 16'd0 || int'(len) + int'(HeaderLen) > FrameBytes) begin
          n = $urandom_range(0, 4);
        end
        // a frame cut short lets the next header be read as payload
        if ($urandom_range(0, 19) == 0) begin
          n = $urandom_range(0, n);
        end
        sync_heavy = ($urandom_range(0, 3) == 0);
        send_sync();
        send_length(len);
        repeat (n) send_byte(sync_heavy ? hunt_byte() : 8'($urandom));
      end else if (pick < 78) begin
        send_sync();
        send_length(odd_length());
        repeat ($urandom_range(0, 3)) send_byte(hunt_byte());
      end else if (pick < 90) begin
        cut = $urandom_range(1, SyncLen - 1);
        for (int i = 0; i < cut; i++) begin
          send_byte(SyncWord[2'(i)]);
        end
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(hunt_byte());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_flow
    logic [6:0] setting;
    int budget;
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.expected_length = 7'd0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset setting of one payload byte
    // good frame with a zero payload byte
    send_sync();
    send_length(16'd1);
    send_byte(8'h00);
    // doubled first sync letter, then an all-ones length
    send_byte(SyncWord[0]);
    send_sync();
    send_length(16'hffff);
    // hunt restarts on the first letter mid-word, then zero length
    send_byte(SyncWord[0]);
    send_byte(SyncWord[1]);
    send_sync();
    send_length(16'd0);

    // settings: largest that fits, zero, all ones, just oversized, one, then small ones
    for (int k = 0; k < 9; k++) begin
      case (k)
        0: setting = 7'd122;
        1: setting = 7'd0;
        2: setting = 7'd127;
        3: setting = 7'd123;
        4: setting = 7'd1;
        default: setting = 7'($urandom_range(1, 12));
      endcase
      budget = (setting == 7'd122) ? 140 : 50;
      settle();
      write_expected_length(setting);
      calm = (k == 5);
      run_traffic(budget);
    end

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
